@@ design/ordl_pkg.sv @@
// Package for the ordered list engine.
// Holds the command, status and sequencer state codes; no dependencies.
package ordl_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		CMD_STATUS   = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_INS_TAIL = 3'd2,
		CMD_DEL_HEAD = 3'd3,
		CMD_DEL_TAIL = 3'd4,
		CMD_DEL_VAL  = 3'd5,
		CMD_REPLACE  = 3'd6,
		CMD_SEARCH   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_EMPTY     = 2'd2,
		STS_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_REPLACE,
		ST_SHIFT,
		ST_VIEW_HEAD,
		ST_VIEW_TAIL,
		ST_VIEW_CAPT,
		ST_RESP
	} state_t;

endpackage

@@ design/ordl_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ordl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/ordl_unit.sv @@
// Shared address and compare unit: ring address of a list position, and
// equality of a stored word against the search key. Uses ordl_pkg.
module ordl_unit #(
	parameter int CAPACITY = 16,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic [AW-1:0]               base,
	input  logic [AW-1:0]               offset,
	input  logic [ordl_pkg::DATA_W-1:0] key,
	input  logic [ordl_pkg::DATA_W-1:0] word,
	output logic [AW-1:0]               addr,
	output logic                        hit
);

	import ordl_pkg::*;

	localparam logic [AW:0] CAP_W = (AW+1)'(CAPACITY);

	logic [AW:0] sum;
	logic [AW:0] wrapped;

	always_comb begin
		sum     = {1'b0, base} + {1'b0, offset};
		wrapped = (sum >= CAP_W) ? (sum - CAP_W) : sum;
		addr    = wrapped[AW-1:0];
		hit     = (key == word);
	end

endmodule

@@ design/ordered_list_engine_core.sv @@
// Ordered list engine top level: command sequencer, ring buffer state and
// result register. Uses ordl_pkg, ordl_unit and ordl_ram.
//
// A deque of up to CAPACITY signed 32-bit values held in a ring buffer in
// one RAM, with a head pointer and an element count. One command is taken
// at a time; cmd_ready is high only while the sequencer is idle, and a
// finished result waits in its own register while the next command is
// taken. Every command walks through one shared address/compare unit and
// the single RAM read port: status, inserts and end deletes pass from idle
// through the head view, tail view and capture states to the response
// state (tail view and capture are skipped when the list is empty after
// the command). Delete value, replace and search scan from the head one
// entry per cycle; delete value then moves every later entry down one
// place, one per cycle. No clearing pass is needed after reset.
module ordered_list_engine_core #(
	parameter int CAPACITY = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [2:0]                  command,
	input  logic signed [31:0]          value,
	input  logic signed [31:0]          new_value,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [1:0]                  status,
	output logic signed [31:0]          head_value,
	output logic signed [31:0]          tail_value,
	output logic [4:0]                  entry_total,
	output logic                        is_empty
);

	import ordl_pkg::*;

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int EXT_W = CW + 5;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	state_t state_q, state_d;

	cmd_t              cmd_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] nval_q;
	status_t           sts_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [AW-1:0]     tgt_q;
	logic [DATA_W-1:0] hval_q;
	logic [DATA_W-1:0] tval_q;
	logic              vld_s1;
	logic [CW-1:0]     idx_s1;
	logic [AW-1:0]     addr_s1;

	logic [AW-1:0]     u_off;
	logic [AW-1:0]     u_addr;
	logic              u_hit;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;
	logic [CW-1:0]     cnt_m1;
	logic              accept;
	logic              issue;
	logic              full;
	logic              empty;
	logic              rsp_load;
	logic [EXT_W-1:0]  cnt_ext;
	cmd_t              cmd_in;

	ordl_unit #(.CAPACITY(CAPACITY)) u_unit (
		.base   (head_q),
		.offset (u_off),
		.key    (key_q),
		.word   (ram_rdata),
		.addr   (u_addr),
		.hit    (u_hit)
	);

	ordl_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (u_addr),
		.rdata (ram_rdata)
	);

	assign cmd_in  = cmd_t'(command);
	assign cnt_m1  = count_q - CW'(1);
	assign full    = (count_q == CAP_C);
	assign empty   = (count_q == '0);
	assign accept  = cmd_valid && cmd_ready;
	assign issue   = (idx_q < count_q);
	assign cnt_ext = EXT_W'(count_q);

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		u_off     = '0;
		ram_we    = 1'b0;
		ram_waddr = u_addr;
		ram_wdata = key_q;
		rsp_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				case (cmd_in)
					CMD_INS_HEAD: u_off = AW'(CAPACITY - 1);
					CMD_INS_TAIL: u_off = count_q[AW-1:0];
					default:      u_off = AW'(1);
				endcase
				if (accept) begin
					ram_wdata = value;
					ram_we    = !full && (cmd_in == CMD_INS_HEAD || cmd_in == CMD_INS_TAIL);
					if (!empty && (cmd_in == CMD_DEL_VAL || cmd_in == CMD_REPLACE ||
							cmd_in == CMD_SEARCH)) begin
						state_d = ST_SEARCH;
					end else begin
						state_d = ST_VIEW_HEAD;
					end
				end
			end
			ST_SEARCH: begin
				u_off = idx_q[AW-1:0];
				if (vld_s1 && u_hit) begin
					case (cmd_q)
						CMD_REPLACE: state_d = ST_REPLACE;
						CMD_DEL_VAL: state_d = ST_SHIFT;
						default:     state_d = ST_VIEW_HEAD;
					endcase
				end else if (vld_s1 && idx_s1 == cnt_m1) begin
					state_d = ST_VIEW_HEAD;
				end
			end
			ST_REPLACE: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q;
				ram_wdata = nval_q;
				state_d   = ST_VIEW_HEAD;
			end
			ST_SHIFT: begin
				u_off     = idx_q[AW-1:0];
				ram_we    = vld_s1;
				ram_waddr = tgt_q;
				ram_wdata = ram_rdata;
				if (!issue && !vld_s1) begin
					state_d = ST_VIEW_HEAD;
				end
			end
			ST_VIEW_HEAD: begin
				u_off   = '0;
				state_d = empty ? ST_RESP : ST_VIEW_TAIL;
			end
			ST_VIEW_TAIL: begin
				u_off   = cnt_m1[AW-1:0];
				state_d = ST_VIEW_CAPT;
			end
			ST_VIEW_CAPT: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_valid || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						case (cmd_in)
							CMD_INS_HEAD: if (!full) begin
								head_q  <= u_addr;
								count_q <= count_q + CW'(1);
							end
							CMD_INS_TAIL: if (!full) begin
								count_q <= count_q + CW'(1);
							end
							CMD_DEL_HEAD: if (!empty) begin
								head_q  <= u_addr;
								count_q <= cnt_m1;
							end
							CMD_DEL_TAIL: if (!empty) begin
								count_q <= cnt_m1;
							end
							default: ;
						endcase
					end
				end
				ST_SEARCH: begin
					vld_s1 <= issue && !(vld_s1 && u_hit && cmd_q == CMD_DEL_VAL);
				end
				ST_SHIFT: begin
					vld_s1 <= issue;
					if (!issue && !vld_s1) begin
						count_q <= cnt_m1;
					end
				end
				default: begin
					vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q  <= cmd_in;
					key_q  <= value;
					nval_q <= new_value;
					idx_q  <= '0;
					case (cmd_in)
						CMD_INS_HEAD, CMD_INS_TAIL: sts_q <= full ? STS_FULL : STS_OK;
						CMD_STATUS: sts_q <= STS_OK;
						default: sts_q <= empty ? STS_EMPTY : STS_OK;
					endcase
				end
			end
			ST_SEARCH: begin
				idx_s1  <= idx_q;
				addr_s1 <= u_addr;
				if (vld_s1 && u_hit) begin
					tgt_q <= addr_s1;
					idx_q <= idx_s1 + CW'(1);
				end else begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (vld_s1 && idx_s1 == cnt_m1) begin
						sts_q <= STS_NOT_FOUND;
					end
				end
			end
			ST_SHIFT: begin
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				addr_s1 <= u_addr;
				if (vld_s1) begin
					tgt_q <= addr_s1;
				end
			end
			ST_VIEW_HEAD: begin
				hval_q <= '0;
				tval_q <= '0;
			end
			ST_VIEW_TAIL: begin
				hval_q <= ram_rdata;
			end
			ST_VIEW_CAPT: begin
				tval_q <= ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status      <= sts_q;
			head_value  <= hval_q;
			tail_value  <= tval_q;
			entry_total <= cnt_ext[4:0];
			is_empty    <= empty;
		end
	end

endmodule

@@ sim/ordl_checker.sv @@
`timescale 1ns / 1ps
// Result checker for ordered_list_engine_core: watches both channels, keeps its
// own deque model and compares every result field. Depends on ordl_pkg.
module ordl_checker #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_ready,
	input  logic [2:0]         command,
	input  logic signed [31:0] value,
	input  logic signed [31:0] new_value,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  logic [1:0]         status,
	input  logic signed [31:0] head_value,
	input  logic signed [31:0] tail_value,
	input  logic [4:0]         entry_total,
	input  logic               is_empty,
	output int                 fail_count,
	output int                 waiting
);

	import ordl_pkg::*;

	typedef struct packed {
		status_t            sts;
		logic signed [31:0] head;
		logic signed [31:0] tail;
		logic [4:0]         total;
		logic               empty;
	} list_view_t;

	logic signed [31:0] list_model[$];
	list_view_t         expected_views[$];
	int                 result_no = 0;

	initial begin
		fail_count = 0;
		waiting = 0;
	end

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("ordl_checker: transaction %0d %s: got %0h, expected %0h",
			result_no, field, got, want);
		fail_count++;
	endtask

	// Applies one command to the model and returns the view it should report
	function automatic list_view_t apply_command(input cmd_t op, input logic signed [31:0] v,
			input logic signed [31:0] nv);
		list_view_t view;
		int         pos;
		int         i;
		view.sts = STS_OK;
		pos = -1;
		case (op)
			CMD_INS_HEAD, CMD_INS_TAIL: begin
				if (list_model.size() >= CAPACITY)
					view.sts = STS_FULL;
				else if (op == CMD_INS_HEAD)
					list_model.push_front(v);
				else
					list_model.push_back(v);
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL: begin
				if (list_model.size() == 0)
					view.sts = STS_EMPTY;
				else if (op == CMD_DEL_HEAD)
					void'(list_model.pop_front());
				else
					void'(list_model.pop_back());
			end
			CMD_DEL_VAL, CMD_REPLACE, CMD_SEARCH: begin
				if (list_model.size() == 0) begin
					view.sts = STS_EMPTY;
				end else begin
					for (i = 0; i < list_model.size() && pos < 0; i++)
						if (list_model[i] == v)
							pos = i;
					if (pos < 0)
						view.sts = STS_NOT_FOUND;
					else if (op == CMD_DEL_VAL)
						list_model.delete(pos);
					else if (op == CMD_REPLACE)
						list_model[pos] = nv;
				end
			end
			default: ;
		endcase
		view.total = 5'(list_model.size());
		view.empty = (list_model.size() == 0);
		view.head = view.empty ? '0 : list_model[0];
		view.tail = view.empty ? '0 : list_model[list_model.size() - 1];
		return view;
	endfunction

	always @(posedge clk) begin
		list_view_t want;
		if (!arst_n) begin
			list_model.delete();
			expected_views.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_views.size() == 0) begin
					report_mismatch("result with nothing expected", {30'd0, status}, '0);
				end else begin
					want = expected_views.pop_front();
					if (status !== want.sts)
						report_mismatch("status", {30'd0, status}, {30'd0, want.sts});
					if (head_value !== want.head)
						report_mismatch("head_value", head_value, want.head);
					if (tail_value !== want.tail)
						report_mismatch("tail_value", tail_value, want.tail);
					if (entry_total !== want.total)
						report_mismatch("entry_total", {27'd0, entry_total}, {27'd0, want.total});
					if (is_empty !== want.empty)
						report_mismatch("is_empty", {31'd0, is_empty}, {31'd0, want.empty});
				end
				result_no++;
			end
			if (cmd_valid && cmd_ready)
				expected_views.push_back(apply_command(cmd_t'(command), value, new_value));
		end
		waiting = expected_views.size();
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the ordered_list_engine_core testbench: clock, reset, command stimulus,
// result back-pressure and verdict. Depends on ordl_pkg, ordl_checker and the core.
module testbench;
	import ordl_pkg::*;

	localparam int CAPACITY       = 16;
	localparam int RANDOM_ITEMS   = 2000;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 50;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cmd_valid = 1'b0;
	logic               cmd_ready;
	cmd_t               command = CMD_STATUS;
	logic signed [31:0] value = '0;
	logic signed [31:0] new_value = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] head_value;
	logic signed [31:0] tail_value;
	logic [4:0]         entry_total;
	logic               is_empty;

	int                 fail_count;
	int                 waiting;
	int                 send_idle = 37;
	int                 recv_idle = 83;
	int                 quiet_cycles = 0;
	logic signed [31:0] value_pool[8];

	ordered_list_engine_core #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.value(value),
		.new_value(new_value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.head_value(head_value),
		.tail_value(tail_value),
		.entry_total(entry_total),
		.is_empty(is_empty)
	);

	ordl_checker #(
		.CAPACITY(CAPACITY)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.value(value),
		.new_value(new_value),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.head_value(head_value),
		.tail_value(tail_value),
		.entry_total(entry_total),
		.is_empty(is_empty),
		.fail_count(fail_count),
		.waiting(waiting)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ordered_list_engine_core: mismatch");
			$finish;
		end
	end

	// Valid stays high between back-to-back transactions; it only drops for a gap
	task automatic issue_command(input cmd_t op, input logic signed [31:0] v,
			input logic signed [31:0] nv);
		if ($urandom_range(0, 99) < send_idle) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle)
				@(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= op;
		value <= v;
		new_value <= nv;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
	endtask

	// Mostly a small pool so that searches and deletes hit, with extremes and noise
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom();
			default: return value_pool[$urandom_range(0, 7)];
		endcase
	endfunction

	// trend 0 grows the list, 1 shrinks it, 2 is balanced
	function automatic cmd_t pick_command(input int trend);
		int unsigned bound[3][8] = '{
			'{35, 70, 78, 84, 88, 93, 98, 100},
			'{10, 20, 40, 60, 75, 85, 95, 100},
			'{20, 40, 50, 60, 70, 80, 95, 100}};
		cmd_t order[8] = '{CMD_INS_HEAD, CMD_INS_TAIL, CMD_DEL_HEAD, CMD_DEL_TAIL,
			CMD_DEL_VAL, CMD_REPLACE, CMD_SEARCH, CMD_STATUS};
		int unsigned r;
		r = $urandom_range(0, 99);
		for (int k = 0; k < 8; k++)
			if (r < bound[trend][k])
				return order[k];
		return CMD_STATUS;
	endfunction

	initial begin
		int trend;
		value_pool[0] = '0;
		value_pool[1] = -1;
		for (int k = 2; k < 8; k++)
			value_pool[k] = $urandom();
		trend = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		issue_command(CMD_STATUS, '0, '0);
		issue_command(CMD_DEL_HEAD, '0, '0);
		issue_command(CMD_DEL_TAIL, '0, '0);
		issue_command(CMD_DEL_VAL, '0, '0);
		issue_command(CMD_REPLACE, '0, 32'sd1);
		issue_command(CMD_SEARCH, '0, '0);
		// fill to capacity with extremes and duplicates, then overflow both ends
		for (int k = 0; k < CAPACITY; k++)
			issue_command((k % 2) ? CMD_INS_TAIL : CMD_INS_HEAD,
				(k % 4 == 0) ? 32'sh7FFFFFFF : (k % 4 == 1) ? 32'sh80000000 :
				(k % 4 == 2) ? 32'sd0 : -32'sd1, '0);
		issue_command(CMD_INS_HEAD, 32'sd7, '0);
		issue_command(CMD_INS_TAIL, 32'sd7, '0);
		// first match only, then misses
		issue_command(CMD_SEARCH, -32'sd1, '0);
		issue_command(CMD_REPLACE, -32'sd1, 32'sh12345678);
		issue_command(CMD_DEL_VAL, -32'sd1, '0);
		issue_command(CMD_SEARCH, 32'sh0BADF00D, '0);
		issue_command(CMD_REPLACE, 32'sh0BADF00D, 32'sd3);
		issue_command(CMD_DEL_VAL, 32'sh0BADF00D, '0);
		issue_command(CMD_DEL_HEAD, '0, '0);
		issue_command(CMD_DEL_TAIL, '0, '0);
		issue_command(CMD_STATUS, '0, '0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 37;
					recv_idle = 83;
				end
				1: begin
					send_idle = 83;
					recv_idle = 37;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
				if (n % 40 == 0)
					trend = $urandom_range(0, 2);
				issue_command(pick_command(trend), pick_value(), pick_value());
			end
		end

		cmd_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && waiting == 0)
			$display("ordered_list_engine_core: match");
		else
			$display("ordered_list_engine_core: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
design/ordl_pkg.sv
design/ordl_ram.sv
design/ordl_unit.sv
design/ordered_list_engine_core.sv
sim/ordl_checker.sv
sim/testbench.sv
